// ----- hdl/pce_pkg.sv -----
// Shared types, constants and width helpers for the Pearson correlation engine.
package pce_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int COR_W           = 16;
  localparam int FRAC_BITS       = 14;
  localparam int ROOT_W          = FRAC_BITS + 1;
  localparam int DIV_STEPS       = 2 * FRAC_BITS + 1;
  localparam int DEF_MAX_PAIRS   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // Datapath commands issued by the controller
  typedef struct packed {
    logic acc;
    logic prod;
    logic diff;
    logic mul_step;
    logic div_step;
    logic sqrt_step;
    logic first;
    logic load_out;
  } cmd_t;

  // Used sample width: at most the port width
  function automatic int ext_bits(int sample_bits);
    return (sample_bits < SAMPLE_W) ? sample_bits : SAMPLE_W;
  endfunction

  // Pair counter width
  function automatic int cnt_bits(int max_pairs);
    return $clog2(max_pairs + 1);
  endfunction

  // Width of the unsigned variance and covariance magnitude
  function automatic int mag_bits(int max_pairs, int sample_bits);
    return 2 * cnt_bits(max_pairs) + 2 * ext_bits(sample_bits) - 1;
  endfunction

endpackage

// ----- hdl/pce_smul.sv -----
// Shift-add unsigned multiplier, one multiplier bit per step.
module pce_smul import pce_pkg::*; #(
  parameter int W = 8
) (
  input  logic           clk,
  input  logic           load,
  input  logic           step,
  input  logic [W-1:0]   mcand_in,
  input  logic [W-1:0]   mplier_in,
  output logic [2*W-1:0] product
);

  logic [W-1:0]   mcand;
  logic [2*W-1:0] acc;
  logic [W:0]     upper;

  // Add the multiplicand into the upper half when the low bit is set
  assign upper = {1'b0, acc[2*W-1:W]} + {1'b0, (acc[0] ? mcand : {W{1'b0}})};

  // Load operands, then shift right one bit per step
  always_ff @(posedge clk) begin
    if (load) begin
      mcand <= mcand_in;
      acc   <= {{W{1'b0}}, mplier_in};
    end else if (step) begin
      acc   <= {upper, acc[W-1:1]};
    end
  end

  assign product = acc;

endmodule

// ----- hdl/pce_ctrl.sv -----
// Sequencer for accumulation and the final divide and square root.
module pce_ctrl import pce_pkg::*; #(
  parameter int MAX_PAIRS   = DEF_MAX_PAIRS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic last_pair,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);

  localparam int V_W      = mag_bits(MAX_PAIRS, SAMPLE_BITS);
  localparam int CNT_TOP  = (V_W > DIV_STEPS) ? V_W : DIV_STEPS;
  localparam int STEP_W   = $clog2(CNT_TOP);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PROD = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              out_valid_next;
  logic              cnt_end;

  // End of the current iterative phase
  always_comb begin
    case (state)
      ST_MUL:  cnt_end = (cnt == STEP_W'(V_W - 1));
      ST_DIV:  cnt_end = (cnt == STEP_W'(DIV_STEPS - 1));
      ST_SQRT: cnt_end = (cnt == STEP_W'(ROOT_W - 1));
      default: cnt_end = 1'b0;
    endcase
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    cmd.first  = (cnt == '0);
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (last_pair) state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        cnt_next   = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt_end ? '0 : cnt + 1'b1;
        if (cnt_end) state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt_end ? '0 : cnt + 1'b1;
        if (cnt_end) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt_end ? '0 : cnt + 1'b1;
        if (cnt_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hdl/pce_datapath.sv -----
// Running sums, variance terms, serial multiply, divide and square root.
module pce_datapath import pce_pkg::*; #(
  parameter int MAX_PAIRS   = DEF_MAX_PAIRS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic                cfg_we,
  input  logic [COR_W-1:0]    cfg_wdata,
  input  logic [SAMPLE_W-1:0] sample_a,
  input  logic [SAMPLE_W-1:0] sample_b,
  output logic [COR_W-1:0]    correlation,
  output logic                meets_minimum,
  output logic                degenerate
);

  localparam int EXT     = ext_bits(SAMPLE_BITS);
  localparam int CNT_W   = cnt_bits(MAX_PAIRS);
  localparam int SUM_W   = EXT + CNT_W;
  localparam int SQ_W    = 2 * EXT + CNT_W - 1;
  localparam int CROSS_W = 2 * EXT + CNT_W;
  localparam int V_W     = mag_bits(MAX_PAIRS, SAMPLE_BITS);
  localparam int D_W     = V_W + 1;
  localparam int P_W     = 2 * V_W;

  logic [COR_W-1:0] min_correlation;

  logic signed [EXT-1:0]     a_s, b_s;
  logic signed [2*EXT-1:0]   aa, bb, ab;
  logic [CNT_W-1:0]          pair_count;
  logic signed [SUM_W-1:0]   total_a, total_b;
  logic [SQ_W-1:0]           total_a_squared, total_b_squared;
  logic signed [CROSS_W-1:0] total_cross;
  logic                      room;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_correlation <= '0;
    end else if (cfg_we) begin
      min_correlation <= cfg_wdata;
    end
  end

  // Take the used sample bits as signed values and form the per-pair products
  assign a_s  = sample_a[EXT-1:0];
  assign b_s  = sample_b[EXT-1:0];
  assign aa   = a_s * a_s;
  assign bb   = b_s * b_s;
  assign ab   = a_s * b_s;
  assign room = (pair_count < CNT_W'(MAX_PAIRS));

  // Accumulate; drop pairs past the limit; clear once the sums are consumed
  always_ff @(posedge clk) begin
    if (rst || cmd.prod) begin
      pair_count      <= '0;
      total_a         <= '0;
      total_b         <= '0;
      total_a_squared <= '0;
      total_b_squared <= '0;
      total_cross     <= '0;
    end else if (cmd.acc && room) begin
      pair_count      <= pair_count + 1'b1;
      total_a         <= total_a + SUM_W'(a_s);
      total_b         <= total_b + SUM_W'(b_s);
      total_a_squared <= total_a_squared + SQ_W'($unsigned(aa));
      total_b_squared <= total_b_squared + SQ_W'($unsigned(bb));
      total_cross     <= total_cross + CROSS_W'(ab);
    end
  end

  // Cross products of the sums
  logic signed [CNT_W:0]             n_s;
  logic signed [SQ_W:0]              saa_s, sbb_s;
  logic signed [CNT_W+CROSS_W:0]     m_nab;
  logic signed [2*SUM_W-1:0]         m_ab, m_aa, m_bb;
  logic signed [CNT_W+SQ_W+1:0]      m_naa, m_nbb;
  logic signed [D_W-1:0]             p_nab, p_ab, p_naa, p_aa, p_nbb, p_bb;

  assign n_s   = {1'b0, pair_count};
  assign saa_s = {1'b0, total_a_squared};
  assign sbb_s = {1'b0, total_b_squared};
  assign m_nab = n_s * total_cross;
  assign m_ab  = total_a * total_b;
  assign m_aa  = total_a * total_a;
  assign m_bb  = total_b * total_b;
  assign m_naa = n_s * saa_s;
  assign m_nbb = n_s * sbb_s;

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      p_nab <= D_W'(m_nab);
      p_ab  <= D_W'(m_ab);
      p_naa <= D_W'(m_naa);
      p_aa  <= D_W'(m_aa);
      p_nbb <= D_W'(m_nbb);
      p_bb  <= D_W'(m_bb);
    end
  end

  // Covariance and variance terms
  logic signed [D_W-1:0] cov_d, va_d, vb_d, cov_neg;
  logic [V_W-1:0]        cov_mag;
  logic                  neg, degen;

  assign cov_d   = p_nab - p_ab;
  assign va_d    = p_naa - p_aa;
  assign vb_d    = p_nbb - p_bb;
  assign cov_neg = -cov_d;
  assign cov_mag = cov_d[D_W-1] ? cov_neg[V_W-1:0] : cov_d[V_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      neg   <= cov_d[D_W-1];
      degen <= (va_d == '0) || (vb_d == '0);
    end
  end

  // Squared covariance and product of variances
  logic [P_W-1:0] prod_c, prod_v;

  pce_smul #(.W(V_W)) u_mul_cov (
    .clk       (clk),
    .load      (cmd.diff),
    .step      (cmd.mul_step),
    .mcand_in  (cov_mag),
    .mplier_in (cov_mag),
    .product   (prod_c)
  );

  pce_smul #(.W(V_W)) u_mul_var (
    .clk       (clk),
    .load      (cmd.diff),
    .step      (cmd.mul_step),
    .mcand_in  (va_d[V_W-1:0]),
    .mplier_in (vb_d[V_W-1:0]),
    .product   (prod_v)
  );

  // Restoring divide: quotient of cov^2 * 2^28 over var_a * var_b
  logic [P_W:0]           rem, rem_cur, rem_sub, den;
  logic                   ge;
  logic [DIV_STEPS-1:0]   quot;

  assign rem_cur = cmd.first ? {1'b0, prod_c} : rem;
  assign den     = {1'b0, prod_v};
  assign ge      = (rem_cur >= den);
  assign rem_sub = ge ? (rem_cur - den) : rem_cur;

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      rem  <= {rem_sub[P_W-1:0], 1'b0};
      quot <= {quot[DIV_STEPS-2:0], ge};
    end
  end

  // Bit-by-bit integer square root of the quotient
  logic [ROOT_W-1:0]   root, mask, base, mask_cur, trial;
  logic [2*ROOT_W-1:0] trial_sq;
  logic                fits;

  assign base     = cmd.first ? '0 : root;
  assign mask_cur = cmd.first ? {1'b1, {(ROOT_W-1){1'b0}}} : mask;
  assign trial    = base | mask_cur;
  assign trial_sq = trial * trial;
  assign fits     = (trial_sq <= {1'b0, quot});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_step) begin
      root <= fits ? trial : base;
      mask <= mask_cur >> 1;
    end
  end

  // Apply the sign, compare with the threshold, register the result
  logic [ROOT_W-1:0]      q;
  logic signed [COR_W:0]  r_pos, r_val, thr;

  assign q     = degen ? '0 : root;
  assign r_pos = {{(COR_W+1-ROOT_W){1'b0}}, q};
  assign r_val = neg ? -r_pos : r_pos;
  assign thr   = {min_correlation[COR_W-1], min_correlation};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      correlation   <= r_val[COR_W-1:0];
      meets_minimum <= (r_val >= thr);
      degenerate    <= degen;
    end
  end

endmodule

// ----- hdl/pearson_correlation_engine.sv -----
// Top level of the Pearson correlation engine: controller plus datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per sample pair:
//   sample_a, sample_b and last_pair. Pairs add to the running sums in the
//   cycle they are accepted, one per clock while in_ready is high.
//   A request with last_pair set closes the data set. The engine then drops
//   in_ready and computes r in signed Q1.14, truncated toward zero.
//   The work runs in order: cross products of the sums, variance terms,
//   the bit-serial multiply, a 29-step divide and a 15-step square root.
//   Intake stays closed meanwhile, and longer while a previous result waits.
//   Output channel (out_valid/out_ready) holds correlation, meets_minimum
//   and degenerate in a register until taken; a new data set may stream in
//   while that result waits. A stalled receiver only delays the next result.
//   Pairs beyond MAX_PAIRS are dropped. cfg_we/cfg_wdata write the threshold
//   min_correlation, to be changed only while the engine is idle.
//   Reset (synchronous, rst) clears the sums, the threshold and out_valid.
module pearson_correlation_engine import pce_pkg::*; #(
  parameter int MAX_PAIRS   = DEF_MAX_PAIRS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [COR_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample_a,
  input  logic [SAMPLE_W-1:0] sample_b,
  input  logic                last_pair,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COR_W-1:0]    correlation,
  output logic                meets_minimum,
  output logic                degenerate
);

  cmd_t cmd;

  pce_ctrl #(
    .MAX_PAIRS   (MAX_PAIRS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_pair (last_pair),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pce_datapath #(
    .MAX_PAIRS   (MAX_PAIRS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .sample_a      (sample_a),
    .sample_b      (sample_b),
    .correlation   (correlation),
    .meets_minimum (meets_minimum),
    .degenerate    (degenerate)
  );

  // A closing request stops intake for the computation
  a_close_stops_intake: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_pair |=> !in_ready)
    else $error("intake still open after last pair");

  // Zero variance gives zero correlation
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> correlation == '0)
    else $error("degenerate result with nonzero correlation");

  // Result stays within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(correlation) <= 16'sd16384) &&
                  ($signed(correlation) >= -16'sd16384))
    else $error("correlation out of range");

endmodule
